[rtl/uvs_pkg.sv]
// Package: shared types, constants and the CORDIC angle table.
package uvs_pkg;

  localparam int unsigned CordicSteps = 20;
  localparam logic signed [33:0] CordicX0 = 34'sd652032874;
  localparam logic signed [17:0] Q14One = 18'sd16384;
  localparam logic [7:0] ResetResolution = 8'd16;

  typedef enum logic {
    KIND_VERTEX   = 1'b0,
    KIND_TRIANGLE = 1'b1
  } kind_e;

  typedef struct packed {
    logic        kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [15:0] corner_a;
    logic [15:0] corner_b;
    logic [15:0] corner_c;
    logic        last;
    logic        error;
  } result_t;

  // Vertex data plus cell info handed from the math pipe to the emitter.
  typedef struct packed {
    logic        err;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic        has_tri;
    logic [1:0]  ntri;
    logic [15:0] i00;
    logic [15:0] w;
  } vert_t;

  function automatic logic [33:0] atan_turn(input logic [4:0] i);
    unique case (i)
      5'd0:  atan_turn = 34'd536870912;
      5'd1:  atan_turn = 34'd316933406;
      5'd2:  atan_turn = 34'd167458907;
      5'd3:  atan_turn = 34'd85004756;
      5'd4:  atan_turn = 34'd42667331;
      5'd5:  atan_turn = 34'd21354465;
      5'd6:  atan_turn = 34'd10679840;
      5'd7:  atan_turn = 34'd5340245;
      5'd8:  atan_turn = 34'd2670163;
      5'd9:  atan_turn = 34'd1335087;
      5'd10: atan_turn = 34'd667544;
      5'd11: atan_turn = 34'd333772;
      5'd12: atan_turn = 34'd166886;
      5'd13: atan_turn = 34'd83443;
      5'd14: atan_turn = 34'd41722;
      5'd15: atan_turn = 34'd20861;
      5'd16: atan_turn = 34'd10430;
      5'd17: atan_turn = 34'd5215;
      5'd18: atan_turn = 34'd2608;
      5'd19: atan_turn = 34'd1304;
      default: atan_turn = 34'd0;
    endcase
  endfunction

endpackage

[rtl/uvs_if.sv]
// Valid/ready stream interface carrying a generic payload.
interface uvs_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/uvs_div.sv]
// Radix-2 restoring divider stage chain: q = n / d, two quotient bits per stage.
module uvs_div #(
  parameter int NW = 40,
  parameter int DW = 9,
  parameter int QW = 32,
  parameter int SW = 64
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);
  // Two quotient bits per register stage.
  localparam int Stages = (QW + 1) / 2;
  logic [DW:0]   rem_q  [Stages+1];
  logic [NW-1:0] num_q  [Stages+1];
  logic [QW-1:0] quo_q  [Stages+1];
  logic [DW-1:0] den_q  [Stages+1];
  logic [SW-1:0] side_q [Stages+1];

  always_comb begin
    rem_q[0]  = '0;
    num_q[0]  = num_i;
    quo_q[0]  = '0;
    den_q[0]  = den_i;
    side_q[0] = side_i;
  end

  // Numerator is consumed MSB first; the upper NW-QW bits are below DW.
  for (genvar s = 0; s < Stages; s++) begin : g_st
    logic [DW:0]   r_d;
    logic [NW-1:0] n_d;
    logic [QW-1:0] q_d;
    always_comb begin
      logic [DW+1:0] t;
      r_d = rem_q[s];
      n_d = num_q[s];
      q_d = quo_q[s];
      for (int b = 0; b < 2; b++) begin
        if (2 * s + b < QW) begin
          if (s == 0 && b == 0) begin
            r_d = {1'b0, n_d[NW-1 -: DW]};
          end
          t = {r_d, n_d[NW-DW-1-(2*s+b)]};
          if (t >= {2'b0, den_q[s]}) begin
            r_d = (DW+1)'(t - {2'b0, den_q[s]});
            q_d = {q_d[QW-2:0], 1'b1};
          end else begin
            r_d = t[DW:0];
            q_d = {q_d[QW-2:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= r_d;
        num_q[s+1]  <= n_d;
        quo_q[s+1]  <= q_d;
        den_q[s+1]  <= den_q[s];
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign quo_o  = quo_q[Stages];
  assign side_o = side_q[Stages];
endmodule

[rtl/uvs_cordic.sv]
// Pipelined rotation CORDIC: phase in turns to cos/sin in Q.30, one step per stage.
module uvs_cordic #(
  parameter int SW = 64
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [31:0]         phase_i,
  input  logic [SW-1:0]       side_i,
  output logic signed [33:0]  cos_o,
  output logic signed [33:0]  sin_o,
  output logic [SW-1:0]       side_o
);
  import uvs_pkg::*;

  logic signed [33:0] x_q [CordicSteps+1];
  logic signed [33:0] y_q [CordicSteps+1];
  logic signed [33:0] z_q [CordicSteps+1];
  logic [1:0]         quad_q [CordicSteps+1];
  logic [SW-1:0]      side_q [CordicSteps+1];

  always_comb begin
    x_q[0]    = CordicX0;
    y_q[0]    = '0;
    z_q[0]    = {4'b0, phase_i[29:0]};
    quad_q[0] = phase_i[31:30];
    side_q[0] = side_i;
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    logic signed [33:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][33]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - atan_turn(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + atan_turn(5'(i));
        end
        quad_q[i+1] <= quad_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  always_comb begin
    unique case (quad_q[CordicSteps])
      2'd0: begin cos_o = x_q[CordicSteps];  sin_o = y_q[CordicSteps];  end
      2'd1: begin cos_o = -y_q[CordicSteps]; sin_o = x_q[CordicSteps];  end
      2'd2: begin cos_o = -x_q[CordicSteps]; sin_o = -y_q[CordicSteps]; end
      default: begin cos_o = y_q[CordicSteps]; sin_o = -x_q[CordicSteps]; end
    endcase
  end
  assign side_o = side_q[CordicSteps];
endmodule

[rtl/uvs_emit.sv]
// Result emitter: expands one vertex into its vertex and triangle results.
module uvs_emit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  uvs_pkg::vert_t   vert_i,
  output logic             ready_o,
  uvs_if.source            res
);
  import uvs_pkg::*;

  vert_t      v_q;
  logic       full_q;
  logic [1:0] seq_q;
  result_t    r;
  logic       fin;
  logic [15:0] i01, i10, i11;

  assign i01 = v_q.i00 + 16'd1;
  assign i10 = v_q.i00 + v_q.w;
  assign i11 = i10 + 16'd1;

  always_comb begin
    r = '0;
    fin = 1'b1;
    if (v_q.err) begin
      r.last = 1'b1;
      r.error = 1'b1;
    end else if (seq_q == 2'd0) begin
      r.kind  = KIND_VERTEX;
      r.pos_x = v_q.pos_x;
      r.pos_y = v_q.pos_y;
      r.pos_z = v_q.pos_z;
      r.tex_u = v_q.tex_u;
      r.tex_v = v_q.tex_v;
      fin     = !v_q.has_tri;
      r.last  = fin;
    end else begin
      r.kind = KIND_TRIANGLE;
      if (v_q.ntri == 2'd0) begin
        r.corner_a = v_q.i00; r.corner_b = i10; r.corner_c = i11;
      end else if (v_q.ntri == 2'd1 || seq_q == 2'd1) begin
        r.corner_a = v_q.i00; r.corner_b = i10; r.corner_c = i01;
      end else begin
        r.corner_a = i01; r.corner_b = i10; r.corner_c = i11;
      end
      fin = (v_q.ntri != 2'd2) || (seq_q == 2'd2);
      r.last = fin;
    end
  end

  assign res.valid = full_q;
  assign res.data  = r;
  assign ready_o   = !full_q || (res.ready && fin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      seq_q  <= '0;
    end else if (ready_o) begin
      full_q <= valid_i;
      seq_q  <= '0;
    end else if (res.ready) begin
      seq_q <= seq_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) v_q <= vert_i;
  end
endmodule

[rtl/uv_sphere_mesh_generator.sv]
// Top level of the UV sphere mesh generator.
// Usage:
//   req: one grid point (lat_row, lon_col) per request on a valid/ready sink.
//   res: results on a valid/ready source; a vertex result first, then up to
//   two triangle results for a cell corner, last set on the final one. A
//   point beyond the resolution, or an invalid resolution, gives one error
//   result.
//   resolution_we_i/resolution_i write R while the block is idle; reset sets 16.
// Pipeline: 16 divider stages, 20 CORDIC stages, a product stage and a round
// stage, then the emitter register.
// Throughput: one request per cycle into the pipe while it is not stalled; the
// emitter holds a point until the single result port has taken all of its
// one to three results, so that port sets the sustained rate.
// Stall: the whole pipe advances on one enable; when the last stage holds a
// point the emitter cannot take, every stage holds, nothing is dropped or
// repeated. Reset clears the valid bits of all stages and the emitter.
module uv_sphere_mesh_generator #(
  parameter int MAX_RESOLUTION = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       resolution_we_i,
  input  logic [7:0] resolution_i,
  uvs_if.sink        req,
  uvs_if.source      res
);
  import uvs_pkg::*;

  localparam int DivStages = 16;
  localparam int Depth = DivStages + CordicSteps + 2;

  logic [7:0] res_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_q <= ResetResolution;
    else if (resolution_we_i) res_q <= resolution_i;
  end

  // Valid bits for the whole pipe; one shared enable.
  logic [Depth-1:0] vld_q;
  logic             emit_ready, en;
  assign en = emit_ready || !vld_q[Depth-1];
  assign req.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Depth-2:0], req.valid};
  end

  // Side band through the dividers: lat, lon, R, error flag.
  typedef struct packed {
    logic       err;
    logic [7:0] lat;
    logic [7:0] lon;
    logic [7:0] r;
  } pt_t;
  pt_t p_in;
  logic [7:0] lat_in, lon_in;
  assign lat_in = req.data.lat_row;
  assign lon_in = req.data.lon_col;
  always_comb begin
    p_in.lat = lat_in;
    p_in.lon = lon_in;
    p_in.r   = res_q;
    p_in.err = (res_q < 8'd2) || (32'(res_q) > 32'(MAX_RESOLUTION)) ||
               (lat_in > res_q) || (lon_in > res_q);
  end

  // Longitude phase: (lon<<32 + R/2)/R; latitude: (lat<<32 + R)/(2R).
  // Texture: (n<<16 + R/2)/R from a zero-padded numerator, so n = R still
  // fits the quotient.
  logic [40:0] lon_num, lat_num;
  logic [24:0] tu_num, tv_num;
  // A column at R wraps to angle zero; keep the divider remainder below R.
  logic [7:0] lon_wrap;
  assign lon_wrap = (lon_in == res_q) ? 8'd0 : lon_in;
  assign lon_num = {1'b0, lon_wrap, 32'd0} + 41'(res_q[7:1]);
  assign lat_num = {1'b0, lat_in, 32'd0} + 41'(res_q);
  assign tu_num  = {1'b0, lon_in, 16'd0} + 25'(res_q[7:1]);
  assign tv_num  = {1'b0, lat_in, 16'd0} + 25'(res_q[7:1]);

  logic [31:0] lon_ph, lat_ph;
  logic [31:0] tu_q32, tv_q32;
  pt_t p_div;
  logic [$bits(pt_t)-1:0] s0, s1, s2;
  logic [16:0] tu_w, tv_w;
  logic sd_lat, sd_tu, sd_tv, sc_lat;
  uvs_div #(.NW(41), .DW(9), .QW(32), .SW($bits(pt_t))) u_dlon (
    .clk_i, .en_i(en), .num_i(lon_num), .den_i({1'b0, res_q}),
    .side_i(p_in), .quo_o(lon_ph), .side_o(s0));
  uvs_div #(.NW(41), .DW(9), .QW(32), .SW(1)) u_dlat (
    .clk_i, .en_i(en), .num_i(lat_num), .den_i({res_q, 1'b0}),
    .side_i(1'b0), .quo_o(lat_ph), .side_o(sd_lat));
  uvs_div #(.NW(41), .DW(9), .QW(32), .SW(1)) u_dtu (
    .clk_i, .en_i(en), .num_i({16'd0, tu_num}), .den_i({1'b0, res_q}),
    .side_i(1'b0), .quo_o(tu_q32), .side_o(sd_tu));
  uvs_div #(.NW(41), .DW(9), .QW(32), .SW(1)) u_dtv (
    .clk_i, .en_i(en), .num_i({16'd0, tv_num}), .den_i({1'b0, res_q}),
    .side_i(1'b0), .quo_o(tv_q32), .side_o(sd_tv));
  assign p_div = s0;
  assign tu_w = 17'(tu_q32);
  assign tv_w = 17'(tv_q32);

  localparam int CSW = $bits(pt_t) + 34;
  logic signed [33:0] clon, slon, clat, slat;
  logic [CSW-1:0] c_side;
  uvs_cordic #(.SW(CSW)) u_clon (
    .clk_i, .en_i(en), .phase_i(lon_ph), .side_i({s0, tu_w, tv_w}),
    .cos_o(clon), .sin_o(slon), .side_o(c_side));
  uvs_cordic #(.SW(1)) u_clat (
    .clk_i, .en_i(en), .phase_i(lat_ph), .side_i(1'b0),
    .cos_o(clat), .sin_o(slat), .side_o(sc_lat));
  assign s1 = c_side[CSW-1 -: $bits(pt_t)];
  assign s2 = p_div;

  // Product stage, then round and saturate.
  logic signed [67:0] px_q, pz_q;
  logic signed [33:0] cl_q;
  logic [CSW-1:0]     m_side_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q     <= clon * slat;
      pz_q     <= slon * slat;
      cl_q     <= clat;
      m_side_q <= c_side;
    end
  end

  function automatic logic [15:0] sat(input logic signed [67:0] v);
    if (v > Q14One) sat = 16'(Q14One);
    else if (v < -Q14One) sat = 16'(-Q14One);
    else sat = v[15:0];
  endfunction

  vert_t v_q, v_d;
  pt_t   pm;
  logic signed [67:0] rx, rz, ry;
  logic [15:0] w16;
  always_comb begin
    pm = m_side_q[CSW-1 -: $bits(pt_t)];
    rx = (px_q + (68'sd1 <<< 45)) >>> 46;
    rz = (pz_q + (68'sd1 <<< 45)) >>> 46;
    ry = (68'(-cl_q) + 68'sd32768) >>> 16;
    w16 = 16'(pm.r) + 16'd1;
    v_d = '0;
    v_d.err   = pm.err;
    v_d.pos_x = sat(rx);
    v_d.pos_z = sat(rz);
    v_d.pos_y = sat(ry);
    v_d.tex_u = m_side_q[33:17];
    v_d.tex_v = m_side_q[16:0];
    v_d.has_tri = (pm.lat < pm.r) && (pm.lon < pm.r);
    v_d.ntri  = (pm.lat == 8'd0) ? 2'd0 : ((pm.lat == pm.r - 8'd1) ? 2'd1 : 2'd2);
    v_d.w     = w16;
    v_d.i00   = 16'(pm.lat * w16) + 16'(pm.lon);
  end
  always_ff @(posedge clk_i) begin
    if (en) v_q <= v_d;
  end

  logic unused;
  assign unused = ^{s1, s2, slat, clat, lon_ph, lat_ph, tu_q32[31:17], tv_q32[31:17],
                    sd_lat, sd_tu, sd_tv, sc_lat};

  uvs_emit u_emit (
    .clk_i, .rst_ni, .valid_i(vld_q[Depth-1]), .vert_i(v_q),
    .ready_o(emit_ready), .res(res));
endmodule
